@@ design/ray_cylinder_intersect_defines.svh @@
// ----------------------------------------------------------------------------
// Ray/cylinder intersection assertion macros
// Concurrent checks clocked by clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RAY_CYLINDER_INTERSECT_DEFINES_SVH
`define RAY_CYLINDER_INTERSECT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define RCI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define RCI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RCI_ASSERT_IMP(lbl, ante, cons)
`define RCI_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ design/rci_pkg.sv @@
// ----------------------------------------------------------------------------
// Ray/cylinder intersection package
// Shared types, codes and pipeline constants.
// ----------------------------------------------------------------------------
`default_nettype none

package rci_pkg;

	localparam int MAX_HITS_DEF = 4;
	localparam int SQRT_LAT = 64;
	localparam int DIV_LAT = 34;
	// S1..S5, square root, S6, divider, H1..H3.
	localparam int NSTG = 5 + SQRT_LAT + 1 + DIV_LAT + 3;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_SIDE  = 2'd1;
	localparam logic [1:0] KIND_LOWER = 2'd2;
	localparam logic [1:0] KIND_UPPER = 2'd3;

	localparam logic [1:0] REG_LOWER   = 2'd0;
	localparam logic [1:0] REG_UPPER   = 2'd1;
	localparam logic [1:0] REG_CAPPED  = 2'd2;
	localparam logic [1:0] REG_EPSILON = 2'd3;

	localparam logic [31:0] LOWER_RST  = 32'hFFFF_0000;
	localparam logic [31:0] UPPER_RST  = 32'h0001_0000;
	localparam logic        CAPPED_RST = 1'b1;
	localparam logic [15:0] EPS_RST    = 16'd7;

	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] oz;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic signed [31:0] dz;
	} ray_t;

	typedef struct packed {
		ray_t               ray;
		logic [63:0]        a;
		logic signed [64:0] h;
		logic               side_ok;
		logic               cap_en;
	} ctx_t;

endpackage

`default_nettype wire

@@ design/rci_sqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 128-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rci_sqrt (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [127:0]  val,
	output logic      [63:0]   root
);

	logic [127:0] val_s  [0:rci_pkg::SQRT_LAT-1];
	logic [66:0]  rem_s  [0:rci_pkg::SQRT_LAT-1];
	logic [63:0]  root_s [0:rci_pkg::SQRT_LAT-1];

	for (genvar k = 0; k < rci_pkg::SQRT_LAT; k++) begin : g_stage
		logic [127:0] v_in;
		logic [66:0]  r_in;
		logic [63:0]  q_in;
		logic [66:0]  cur;
		logic [66:0]  trial;

		if (k == 0) begin : g_first
			assign v_in = val;
			assign r_in = '0;
			assign q_in = '0;
		end else begin : g_rest
			assign v_in = val_s[k-1];
			assign r_in = rem_s[k-1];
			assign q_in = root_s[k-1];
		end

		assign cur   = {r_in[64:0], v_in[127-2*k -: 2]};
		assign trial = {1'b0, q_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				val_s[k] <= v_in;
				if (cur >= trial) begin
					rem_s[k]  <= cur - trial;
					root_s[k] <= {q_in[62:0], 1'b1};
				end else begin
					rem_s[k]  <= cur;
					root_s[k] <= {q_in[62:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[rci_pkg::SQRT_LAT-1];

endmodule

`default_nettype wire

@@ design/rci_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined saturating divider
// Unsigned restoring division to a signed Q16.16 result that saturates to
// 32 bits; one quotient bit per stage after an overflow check.
// ----------------------------------------------------------------------------
`default_nettype none

module rci_div #(
	parameter int NW = 81,
	parameter int DW = 64
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [NW-1:0]      num,
	input  wire logic [DW-1:0]      den,
	input  wire logic               neg,
	output logic signed [31:0]      t
);

	localparam int CW = (NW > DW + 32) ? NW : DW + 32;

	logic [CW-1:0] rem_s [0:32];
	logic [31:0]   quo_s [0:32];
	logic [DW-1:0] den_s [0:32];
	logic          neg_s [0:32];
	logic          ovf_s [0:32];
	logic [31:0]   res_s34;

	// A quotient of 2^32 or more saturates in either direction.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= CW'(num);
			quo_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= neg;
			ovf_s[0] <= CW'(num) >= (CW'(den) << 32);
		end
	end

	for (genvar j = 1; j <= 32; j++) begin : g_stage
		logic [CW-1:0] dsh;
		assign dsh = CW'(den_s[j-1]) << (32 - j);

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j] <= den_s[j-1];
				neg_s[j] <= neg_s[j-1];
				ovf_s[j] <= ovf_s[j-1];
				if (rem_s[j-1] >= dsh) begin
					rem_s[j] <= rem_s[j-1] - dsh;
					quo_s[j] <= quo_s[j-1] | (32'd1 << (32 - j));
				end else begin
					rem_s[j] <= rem_s[j-1];
					quo_s[j] <= quo_s[j-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[32]) begin
				if (ovf_s[32] || quo_s[32] > 32'h8000_0000) begin
					res_s34 <= 32'h8000_0000;
				end else begin
					res_s34 <= 32'd0 - quo_s[32];
				end
			end else begin
				if (ovf_s[32] || quo_s[32][31]) begin
					res_s34 <= 32'h7FFF_FFFF;
				end else begin
					res_s34 <= quo_s[32];
				end
			end
		end
	end

	assign t = $signed(res_s34);

endmodule

`default_nettype wire

@@ design/ray_cylinder_intersect.sv @@
// ----------------------------------------------------------------------------
// Ray/cylinder intersection
// Intersects one ray (origin and direction, signed Q16.16) per transaction
// with a unit-radius cylinder about the y axis, bounded in y and optionally
// capped. For each ray it returns the side hits that lie strictly inside the
// bounds, nearer first, then the lower and upper cap hits within radius one,
// at most MAX_HITS items, the last one flagged. A ray with no hit returns one
// item of kind none. The user sets bounds, caps and epsilon over the APB port
// only while the block is idle; the block itself does not enforce this.
// The pipeline is 107 stages deep plus the output register. A ray can enter
// every cycle while in_stall is low; the output register sends one result per
// cycle while out_stall is low, and a ray with more than one result holds the
// pipeline until its last result is taken at the single result port.
// Reset empties the pipeline and loads the default register values.
// While out_stall is high the output holds its item; in_stall stays high
// until the last item of the ray in the output register is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ray_cylinder_intersect_defines.svh"

module ray_cylinder_intersect #(
	parameter int MAX_HITS = rci_pkg::MAX_HITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] origin_x,
	input  wire logic signed [31:0] origin_y,
	input  wire logic signed [31:0] origin_z,
	input  wire logic signed [31:0] dir_x,
	input  wire logic signed [31:0] dir_y,
	input  wire logic signed [31:0] dir_z,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      hit_distance,
	output logic [1:0]              hit_kind,
	output logic                    last,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int NSTG = rci_pkg::NSTG;

	// Configuration registers.
	logic [31:0] lower_q;
	logic [31:0] upper_q;
	logic        capped_q;
	logic [15:0] eps_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q  <= rci_pkg::LOWER_RST;
			upper_q  <= rci_pkg::UPPER_RST;
			capped_q <= rci_pkg::CAPPED_RST;
			eps_q    <= rci_pkg::EPS_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				rci_pkg::REG_LOWER:   lower_q  <= pwdata;
				rci_pkg::REG_UPPER:   upper_q  <= pwdata;
				rci_pkg::REG_CAPPED:  capped_q <= pwdata[0];
				rci_pkg::REG_EPSILON: eps_q    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			rci_pkg::REG_LOWER:   prdata = lower_q;
			rci_pkg::REG_UPPER:   prdata = upper_q;
			rci_pkg::REG_CAPPED:  prdata = {31'd0, capped_q};
			rci_pkg::REG_EPSILON: prdata = {16'd0, eps_q};
			default:              prdata = '0;
		endcase
	end

	// Global pipeline advance.
	logic          adv;
	logic [NSTG-1:0] vld_s;

	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTG-2:0], in_valid};
		end
	end

	// S1: products of the ray terms.
	rci_pkg::ray_t      ray_s1;
	logic signed [63:0] dxx_s1, dzz_s1, oxdx_s1, ozdz_s1, oxx_s1, ozz_s1;
	logic               cap_en_s1;
	logic [31:0]        dy_mag;

	assign dy_mag = dir_y[31] ? 32'd0 - dir_y : dir_y;

	always_ff @(posedge clk) begin
		if (adv) begin
			ray_s1    <= '{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z};
			dxx_s1    <= dir_x * dir_x;
			dzz_s1    <= dir_z * dir_z;
			oxdx_s1   <= origin_x * dir_x;
			ozdz_s1   <= origin_z * dir_z;
			oxx_s1    <= origin_x * origin_x;
			ozz_s1    <= origin_z * origin_z;
			cap_en_s1 <= capped_q && (dy_mag > {16'd0, eps_q});
		end
	end

	// S2: quadratic coefficients a, h and c.
	rci_pkg::ctx_t      ctx_s2;
	logic [63:0]        hm_s2, cm_s2;
	logic               cneg_s2;
	logic [63:0]        a_c;
	logic signed [64:0] h_c, c_c;
	logic [63:0]        oo_c;

	always_comb begin
		a_c  = dxx_s1 + dzz_s1;
		h_c  = {oxdx_s1[63], oxdx_s1} + {ozdz_s1[63], ozdz_s1};
		oo_c = oxx_s1 + ozz_s1;
		c_c  = $signed({1'b0, oo_c}) - 65'sh1_0000_0000;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s2.ray     <= ray_s1;
			ctx_s2.a       <= a_c;
			ctx_s2.h       <= h_c;
			ctx_s2.side_ok <= a_c > {32'd0, eps_q, 16'd0};
			ctx_s2.cap_en  <= cap_en_s1;
			hm_s2          <= h_c[64] ? 64'(-h_c) : h_c[63:0];
			cm_s2          <= c_c[64] ? 64'(-c_c) : c_c[63:0];
			cneg_s2        <= c_c[64];
		end
	end

	// S3: partial products of h*h and a*|c|.
	rci_pkg::ctx_t ctx_s3;
	logic          cneg_s3;
	logic [63:0]   hll_s3, hlh_s3, hhh_s3;
	logic [63:0]   ac0_s3, ac1_s3, ac2_s3, ac3_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s3  <= ctx_s2;
			cneg_s3 <= cneg_s2;
			hll_s3  <= hm_s2[31:0] * hm_s2[31:0];
			hlh_s3  <= hm_s2[31:0] * hm_s2[63:32];
			hhh_s3  <= hm_s2[63:32] * hm_s2[63:32];
			ac0_s3  <= ctx_s2.a[31:0] * cm_s2[31:0];
			ac1_s3  <= ctx_s2.a[31:0] * cm_s2[63:32];
			ac2_s3  <= ctx_s2.a[63:32] * cm_s2[31:0];
			ac3_s3  <= ctx_s2.a[63:32] * cm_s2[63:32];
		end
	end

	// S4: full 128-bit products.
	rci_pkg::ctx_t ctx_s4;
	logic          cneg_s4;
	logic [127:0]  hsq_s4, ac_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s4  <= ctx_s3;
			cneg_s4 <= cneg_s3;
			hsq_s4  <= (128'(hhh_s3) << 64) + (128'(hlh_s3) << 33) + 128'(hll_s3);
			ac_s4   <= (128'(ac3_s3) << 64) + (128'(ac1_s3) << 32)
				+ (128'(ac2_s3) << 32) + 128'(ac0_s3);
		end
	end

	// S5: discriminant.
	rci_pkg::ctx_t ctx_s5;
	logic [127:0]  disc_s5;
	logic [127:0]  disc_c;
	rci_pkg::ctx_t ctx5_c;

	assign disc_c = cneg_s4 ? hsq_s4 + ac_s4 : hsq_s4 - ac_s4;

	always_comb begin
		ctx5_c         = ctx_s4;
		ctx5_c.side_ok = ctx_s4.side_ok && !disc_c[127];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s5  <= ctx5_c;
			disc_s5 <= disc_c[127] ? '0 : disc_c;
		end
	end

	// Square root, with the context delayed alongside.
	logic [63:0]   root;
	rci_pkg::ctx_t ctx_sq [0:rci_pkg::SQRT_LAT-1];

	rci_sqrt u_sqrt (
		.clk  (clk),
		.en   (adv),
		.val  (disc_s5),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_sq[0] <= ctx_s5;
			for (int k = 1; k < rci_pkg::SQRT_LAT; k++) begin
				ctx_sq[k] <= ctx_sq[k-1];
			end
		end
	end

	// S6: numerators and divisors of the four distances.
	rci_pkg::ctx_t      ctx_s6;
	logic [80:0]        n0_s6, n1_s6;
	logic               neg0_s6, neg1_s6;
	logic [47:0]        nl_s6, nu_s6;
	logic               negl_s6, negu_s6;
	logic [31:0]        dym_s6;
	logic signed [65:0] hx_c, n0_c, n1_c;
	logic signed [32:0] nl_c, nu_c;
	logic [64:0]        m0_c, m1_c;
	logic [31:0]        ml_c, mu_c;
	logic signed [31:0] oy6;
	logic signed [31:0] dy6;

	always_comb begin
		oy6  = ctx_sq[rci_pkg::SQRT_LAT-1].ray.oy;
		dy6  = ctx_sq[rci_pkg::SQRT_LAT-1].ray.dy;
		hx_c = {ctx_sq[rci_pkg::SQRT_LAT-1].h[64], ctx_sq[rci_pkg::SQRT_LAT-1].h};
		n0_c = -hx_c - $signed({2'b00, root});
		n1_c = -hx_c + $signed({2'b00, root});
		m0_c = n0_c[65] ? 65'(-n0_c) : n0_c[64:0];
		m1_c = n1_c[65] ? 65'(-n1_c) : n1_c[64:0];
		nl_c = $signed({lower_q[31], lower_q}) - $signed({oy6[31], oy6});
		nu_c = $signed({upper_q[31], upper_q}) - $signed({oy6[31], oy6});
		ml_c = nl_c[32] ? 32'(-nl_c) : nl_c[31:0];
		mu_c = nu_c[32] ? 32'(-nu_c) : nu_c[31:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s6  <= ctx_sq[rci_pkg::SQRT_LAT-1];
			n0_s6   <= {m0_c, 16'd0};
			n1_s6   <= {m1_c, 16'd0};
			neg0_s6 <= n0_c[65];
			neg1_s6 <= n1_c[65];
			nl_s6   <= {ml_c, 16'd0};
			nu_s6   <= {mu_c, 16'd0};
			negl_s6 <= nl_c[32] != dy6[31];
			negu_s6 <= nu_c[32] != dy6[31];
			dym_s6  <= dy6[31] ? 32'd0 - dy6 : dy6;
		end
	end

	// Dividers, with the context delayed alongside.
	logic signed [31:0] t0, t1, tl, tu;
	rci_pkg::ctx_t      ctx_dv [0:rci_pkg::DIV_LAT-1];

	rci_div #(.NW(81), .DW(64)) u_div_t0 (
		.clk (clk), .en (adv), .num (n0_s6), .den (ctx_s6.a), .neg (neg0_s6), .t (t0)
	);
	rci_div #(.NW(81), .DW(64)) u_div_t1 (
		.clk (clk), .en (adv), .num (n1_s6), .den (ctx_s6.a), .neg (neg1_s6), .t (t1)
	);
	rci_div #(.NW(48), .DW(32)) u_div_tl (
		.clk (clk), .en (adv), .num (nl_s6), .den (dym_s6), .neg (negl_s6), .t (tl)
	);
	rci_div #(.NW(48), .DW(32)) u_div_tu (
		.clk (clk), .en (adv), .num (nu_s6), .den (dym_s6), .neg (negu_s6), .t (tu)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_dv[0] <= ctx_s6;
			for (int k = 1; k < rci_pkg::DIV_LAT; k++) begin
				ctx_dv[k] <= ctx_dv[k-1];
			end
		end
	end

	// H1: hit point products.
	rci_pkg::ctx_t      ctx_h1;
	logic signed [31:0] t0_h1, t1_h1, tl_h1, tu_h1;
	logic signed [63:0] py0_h1, py1_h1, pxl_h1, pzl_h1, pxu_h1, pzu_h1;
	rci_pkg::ray_t      rd;

	assign rd = ctx_dv[rci_pkg::DIV_LAT-1].ray;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_h1 <= ctx_dv[rci_pkg::DIV_LAT-1];
			t0_h1  <= t0;
			t1_h1  <= t1;
			tl_h1  <= tl;
			tu_h1  <= tu;
			py0_h1 <= t0 * $signed(rd.dy);
			py1_h1 <= t1 * $signed(rd.dy);
			pxl_h1 <= tl * $signed(rd.dx);
			pzl_h1 <= tl * $signed(rd.dz);
			pxu_h1 <= tu * $signed(rd.dx);
			pzu_h1 <= tu * $signed(rd.dz);
		end
	end

	// H2: height tests and cap point magnitudes.
	logic               side_ok_h2, cap_en_h2;
	logic [31:0]        t_h2 [0:3];
	logic               ok0_h2, ok1_h2;
	logic [31:0]        xl_h2, zl_h2, xu_h2, zu_h2;
	logic               smalll_h2, specl_h2, smallu_h2, specu_h2;
	logic signed [63:0] oy64, ox64, oz64, lo64, hi64, y0_c, y1_c;
	logic signed [63:0] xl_c, zl_c, xu_c, zu_c;
	logic [63:0]        xlm, zlm, xum, zum;

	always_comb begin
		oy64 = {{16{ctx_h1.ray.oy[31]}}, ctx_h1.ray.oy, 16'd0};
		ox64 = {{16{ctx_h1.ray.ox[31]}}, ctx_h1.ray.ox, 16'd0};
		oz64 = {{16{ctx_h1.ray.oz[31]}}, ctx_h1.ray.oz, 16'd0};
		lo64 = {{16{lower_q[31]}}, lower_q, 16'd0};
		hi64 = {{16{upper_q[31]}}, upper_q, 16'd0};
		y0_c = oy64 + py0_h1;
		y1_c = oy64 + py1_h1;
		xl_c = ox64 + pxl_h1;
		zl_c = oz64 + pzl_h1;
		xu_c = ox64 + pxu_h1;
		zu_c = oz64 + pzu_h1;
		xlm  = xl_c[63] ? 64'(-xl_c) : xl_c;
		zlm  = zl_c[63] ? 64'(-zl_c) : zl_c;
		xum  = xu_c[63] ? 64'(-xu_c) : xu_c;
		zum  = zu_c[63] ? 64'(-zu_c) : zu_c;
	end

	// A coordinate of magnitude 2^32 or more lies inside the unit circle only
	// when it is exactly one and the other coordinate is zero.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_ok_h2 <= ctx_h1.side_ok;
			cap_en_h2  <= ctx_h1.cap_en;
			t_h2[0]    <= t0_h1;
			t_h2[1]    <= t1_h1;
			t_h2[2]    <= tl_h1;
			t_h2[3]    <= tu_h1;
			ok0_h2     <= (lo64 < y0_c) && (y0_c < hi64);
			ok1_h2     <= (lo64 < y1_c) && (y1_c < hi64);
			xl_h2      <= xlm[31:0];
			zl_h2      <= zlm[31:0];
			xu_h2      <= xum[31:0];
			zu_h2      <= zum[31:0];
			smalll_h2  <= (xlm[63:32] == 32'd0) && (zlm[63:32] == 32'd0);
			smallu_h2  <= (xum[63:32] == 32'd0) && (zum[63:32] == 32'd0);
			specl_h2   <= (xlm == 64'h1_0000_0000 && zlm == 64'd0)
				|| (zlm == 64'h1_0000_0000 && xlm == 64'd0);
			specu_h2   <= (xum == 64'h1_0000_0000 && zum == 64'd0)
				|| (zum == 64'h1_0000_0000 && xum == 64'd0);
		end
	end

	// H3: squares of the cap point coordinates.
	logic        side_ok_h3, cap_en_h3, ok0_h3, ok1_h3;
	logic [31:0] t_h3 [0:3];
	logic [63:0] sxl_h3, szl_h3, sxu_h3, szu_h3;
	logic        smalll_h3, specl_h3, smallu_h3, specu_h3;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_ok_h3 <= side_ok_h2;
			cap_en_h3  <= cap_en_h2;
			ok0_h3     <= ok0_h2;
			ok1_h3     <= ok1_h2;
			t_h3       <= t_h2;
			sxl_h3     <= xl_h2 * xl_h2;
			szl_h3     <= zl_h2 * zl_h2;
			sxu_h3     <= xu_h2 * xu_h2;
			szu_h3     <= zu_h2 * zu_h2;
			smalll_h3  <= smalll_h2;
			specl_h3   <= specl_h2;
			smallu_h3  <= smallu_h2;
			specu_h3   <= specu_h2;
		end
	end

	// Hit mask, trimmed to the first MAX_HITS hits in order.
	logic [3:0] raw_mask, keep_mask;
	logic [2:0] cnt;
	logic       capl_ok, capu_ok;

	always_comb begin
		capl_ok = specl_h3 || (smalll_h3
			&& ({1'b0, sxl_h3} + {1'b0, szl_h3}) <= 65'h1_0000_0000_0000_0000);
		capu_ok = specu_h3 || (smallu_h3
			&& ({1'b0, sxu_h3} + {1'b0, szu_h3}) <= 65'h1_0000_0000_0000_0000);
		raw_mask = {cap_en_h3 && capu_ok, cap_en_h3 && capl_ok,
			side_ok_h3 && ok1_h3, side_ok_h3 && ok0_h3};
		cnt = '0;
		for (int i = 0; i < 4; i++) begin
			keep_mask[i] = raw_mask[i] && (int'(cnt) < MAX_HITS);
			cnt = cnt + 3'(raw_mask[i]);
		end
	end

	// Output register: sends the hits of one ray, one transaction per cycle while out_stall is low.
	logic        ser_vld_q;
	logic [3:0]  ser_mask_q;
	logic [31:0] ser_t_q [0:3];
	logic [3:0]  rest_mask;

	assign rest_mask = ser_mask_q & (ser_mask_q - 4'd1);
	assign last      = rest_mask == 4'd0;
	assign out_valid = ser_vld_q;
	assign adv       = !ser_vld_q || (!out_stall && last);

	always_comb begin
		if (ser_mask_q[0]) begin
			hit_distance = $signed(ser_t_q[0]);
			hit_kind     = rci_pkg::KIND_SIDE;
		end else if (ser_mask_q[1]) begin
			hit_distance = $signed(ser_t_q[1]);
			hit_kind     = rci_pkg::KIND_SIDE;
		end else if (ser_mask_q[2]) begin
			hit_distance = $signed(ser_t_q[2]);
			hit_kind     = rci_pkg::KIND_LOWER;
		end else if (ser_mask_q[3]) begin
			hit_distance = $signed(ser_t_q[3]);
			hit_kind     = rci_pkg::KIND_UPPER;
		end else begin
			hit_distance = '0;
			hit_kind     = rci_pkg::KIND_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_vld_q <= 1'b0;
		end else if (adv) begin
			ser_vld_q <= vld_s[NSTG-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ser_mask_q <= keep_mask;
			ser_t_q    <= t_h3;
		end else if (!out_stall) begin
			ser_mask_q <= rest_mask;
		end
	end

	`RCI_ASSERT_IMP(a_hold_on_stall, ser_vld_q && out_stall, in_stall)
	`RCI_ASSERT_IMP(a_none_is_last, out_valid && hit_kind == rci_pkg::KIND_NONE, last)
	`RCI_ASSERT_NXT(a_more_follow, out_valid && !out_stall && !last, out_valid)

endmodule

`default_nettype wire
